[design/pen_stroke_point_simplifier_core_macros.svh]
// ----------------------------------------------------------------------------
// pen stroke point simplifier - assertion macros
// Shared property wrappers for the port checker, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef PEN_STROKE_POINT_SIMPLIFIER_CORE_MACROS_SVH
`define PEN_STROKE_POINT_SIMPLIFIER_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PSSIMP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pen stroke simplifier check failed");

// consequent must hold in the cycle after the antecedent
`define PSSIMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pen stroke simplifier check failed");

`endif

[design/pssimp_pkg.sv]
// ----------------------------------------------------------------------------
// pssimp_pkg
// Types and constants shared by the pen stroke simplifier controller and
// datapath: register map, state encoding, command and status bundles.
// ----------------------------------------------------------------------------
package pssimp_pkg;

    // configuration register map
    localparam int PRECISION_W = 16;
    localparam int PRES_TOL_W  = 10;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [PRECISION_W-1:0] PRECISION_RESET = 16'd16;
    localparam logic [PRES_TOL_W-1:0]  PRES_TOL_RESET  = 10'd51;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PRECISION = 1'b0,
        REG_PRES_TOL  = 1'b1
    } t_cfg_reg;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_DOT,
        S_CAP_DOT,
        S_RHS,
        S_LHS,
        S_CAP_LHS,
        S_DECIDE,
        S_EMIT_MID,
        S_TAIL,
        S_EMIT_NEW
    } t_state;

    // how many samples of the current stroke are held
    typedef enum logic [1:0] {
        SEEN_NONE,
        SEEN_ONE,
        SEEN_TWO
    } t_seen;

    // operand set of the four multiplier lanes
    typedef enum logic [1:0] {
        MP_SQ,
        MP_DOT,
        MP_RHS,
        MP_LHS
    } t_mul_phase;

    typedef struct packed {
        logic       load_in;
        t_mul_phase mul_phase;
        logic       cap_len;
        logic       cap_dot;
        logic       cap_rhs;
        logic       cap_lhs;
        logic       old_from_mid;
        logic       old_from_in;
        logic       mid_from_in;
        logic       emit;
        logic       emit_new;
    } t_dp_cmd;

    typedef struct packed {
        logic drop_ok;
        logic out_free;
        logic in_end;
    } t_dp_status;

endpackage

[design/pssimp_ctrl.sv]
// ----------------------------------------------------------------------------
// pssimp_ctrl
// Sequencer for the simplifier: accepts one sample, steps the datapath
// through the geometry test and orders the kept samples to the output.
// ----------------------------------------------------------------------------
module pssimp_ctrl
    import pssimp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_valid,
    output logic       o_s_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    t_seen  r_seen, n_seen;
    logic   r_keep_next, n_keep_next;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= SEEN_NONE;
            r_keep_next <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_keep_next <= n_keep_next;
        end
    end

    // next state and stroke bookkeeping
    always_comb begin
        n_state     = r_state;
        n_seen      = r_seen;
        n_keep_next = r_keep_next;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    unique case (r_seen)
                        SEEN_NONE: n_state = S_EMIT_NEW;
                        SEEN_ONE:  n_state = S_TAIL;
                        SEEN_TWO:  n_state = r_keep_next ? S_EMIT_MID : S_SQ;
                        default:   n_state = S_EMIT_NEW;
                    endcase
                end
            end
            S_SQ:      n_state = S_DOT;
            S_DOT:     n_state = S_CAP_DOT;
            S_CAP_DOT: n_state = S_RHS;
            S_RHS:     n_state = S_LHS;
            S_LHS:     n_state = S_CAP_LHS;
            S_CAP_LHS: n_state = S_DECIDE;
            S_DECIDE: begin
                if (i_status.drop_ok) begin
                    n_keep_next = 1'b1;
                    n_state     = S_TAIL;
                end else begin
                    n_state = S_EMIT_MID;
                end
            end
            S_EMIT_MID: begin
                if (i_status.out_free) begin
                    n_keep_next = 1'b0;
                    n_state     = S_TAIL;
                end
            end
            S_TAIL: begin
                if (i_status.in_end) begin
                    n_state = S_EMIT_NEW;
                end else begin
                    n_seen  = SEEN_TWO;
                    n_state = S_IDLE;
                end
            end
            S_EMIT_NEW: begin
                if (i_status.out_free) begin
                    n_seen      = (r_seen == SEEN_NONE && !i_status.in_end) ? SEEN_ONE
                                                                           : SEEN_NONE;
                    n_keep_next = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands per state
    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready     = 1'b1;
                o_cmd.load_in = i_s_valid;
            end
            S_SQ: o_cmd.mul_phase = MP_SQ;
            S_DOT: begin
                o_cmd.mul_phase = MP_DOT;
                o_cmd.cap_len   = 1'b1;
            end
            S_CAP_DOT: o_cmd.cap_dot = 1'b1;
            S_RHS: o_cmd.mul_phase = MP_RHS;
            S_LHS: begin
                o_cmd.mul_phase = MP_LHS;
                o_cmd.cap_rhs   = 1'b1;
            end
            S_CAP_LHS: o_cmd.cap_lhs = 1'b1;
            S_DECIDE: o_cmd.old_from_mid = i_status.drop_ok;
            S_EMIT_MID: begin
                o_cmd.emit         = i_status.out_free;
                o_cmd.old_from_mid = i_status.out_free;
            end
            S_TAIL: o_cmd.mid_from_in = !i_status.in_end;
            S_EMIT_NEW: begin
                o_cmd.emit        = i_status.out_free;
                o_cmd.emit_new    = 1'b1;
                o_cmd.old_from_in = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

[design/pssimp_dp.sv]
// ----------------------------------------------------------------------------
// pssimp_dp
// Datapath of the simplifier: sample registers, four shared multiplier
// lanes, length / dot / cross accumulation, the exact deviation compare
// and the output register.
// ----------------------------------------------------------------------------
module pssimp_dp
    import pssimp_pkg::*;
#(
    parameter int COORD_WIDTH    = 16,
    parameter int PRESSURE_WIDTH = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_dp_cmd                          i_cmd,
    output t_dp_status                       o_status,
    input  logic signed [COORD_WIDTH-1:0]    i_in_x,
    input  logic signed [COORD_WIDTH-1:0]    i_in_y,
    input  logic        [PRESSURE_WIDTH-1:0] i_in_p,
    input  logic                             i_in_end,
    input  logic                             i_cfg_we,
    input  logic        [CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic        [CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic signed [COORD_WIDTH-1:0]    o_out_x,
    output logic signed [COORD_WIDTH-1:0]    o_out_y,
    output logic        [PRESSURE_WIDTH-1:0] o_out_p,
    output logic                             o_out_last
);

    localparam int CW     = COORD_WIDTH;
    localparam int DIFF_W = CW + 1;
    localparam int LEN_W  = 2 * CW + 1;
    localparam int DOT_W  = 2 * CW + 2;
    localparam int DIG_W  = (CW + 1 > PRECISION_W) ? CW + 1 : PRECISION_W;
    localparam int MUL_W  = DIG_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int PAIR_W = 2 * DIG_W;
    localparam int WIDE_W = 4 * DIG_W;
    localparam int SQ_W   = 2 * PRECISION_W;
    localparam int PT_W   = (PRESSURE_WIDTH > PRES_TOL_W) ? PRESSURE_WIDTH : PRES_TOL_W;

    // configuration and derived precision square
    logic [PRECISION_W-1:0] r_precision;
    logic [PRES_TOL_W-1:0]  r_pres_tol;
    logic [SQ_W-1:0]        r_prec_sq;

    // sample registers
    logic signed [CW-1:0]             r_in_x, r_in_y, r_mid_x, r_mid_y, r_old_x, r_old_y;
    logic        [PRESSURE_WIDTH-1:0] r_in_p, r_mid_p, r_old_p;
    logic                             r_in_end;

    // arithmetic registers
    logic signed [PROD_W-1:0] r_prod [4];
    logic        [LEN_W-1:0]  r_l1, r_l2, r_lmin, r_cmag;
    logic signed [DOT_W-1:0]  r_dot, r_cross;
    logic        [WIDE_W-1:0] r_rhs, r_lhs;
    logic                     r_pres_ok;

    // output register
    logic                             r_out_valid;
    logic signed [CW-1:0]             r_out_x, r_out_y;
    logic        [PRESSURE_WIDTH-1:0] r_out_p;
    logic                             r_out_last;

    logic signed [DIFF_W-1:0] w_dx1, w_dy1, w_dx2, w_dy2;
    logic signed [MUL_W-1:0]  w_ex1, w_ey1, w_ex2, w_ey2;
    logic        [PAIR_W-1:0] w_lmin_ext, w_cmag_ext, w_prec_ext, w_wide_a, w_wide_b;
    logic signed [MUL_W-1:0]  w_a_lo, w_a_hi, w_b_lo, w_b_hi;
    logic signed [MUL_W-1:0]  w_op_a [4];
    logic signed [MUL_W-1:0]  w_op_b [4];
    logic signed [PROD_W-1:0] w_sum01, w_sum23, w_dif23;
    logic        [DOT_W-1:0]  w_cross_neg;
    logic        [WIDE_W-1:0] w_wide_sum;
    logic        [PT_W-1:0]   w_old_p, w_mid_p, w_in_p, w_pd1, w_pd2;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_precision <= PRECISION_RESET;
            r_pres_tol  <= PRES_TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_PRECISION: r_precision <= i_cfg_wdata[PRECISION_W-1:0];
                REG_PRES_TOL:  r_pres_tol  <= i_cfg_wdata[PRES_TOL_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prec_sq <= SQ_W'(r_precision) * SQ_W'(r_precision);
    end

    // input, middle and older samples
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_x   <= i_in_x;
            r_in_y   <= i_in_y;
            r_in_p   <= i_in_p;
            r_in_end <= i_in_end;
        end
        if (i_cmd.mid_from_in) begin
            r_mid_x <= r_in_x;
            r_mid_y <= r_in_y;
            r_mid_p <= r_in_p;
        end
        if (i_cmd.old_from_mid) begin
            r_old_x <= r_mid_x;
            r_old_y <= r_mid_y;
            r_old_p <= r_mid_p;
        end else if (i_cmd.old_from_in) begin
            r_old_x <= r_in_x;
            r_old_y <= r_in_y;
            r_old_p <= r_in_p;
        end
    end

    // segment vectors
    assign w_dx1 = DIFF_W'(r_mid_x) - DIFF_W'(r_old_x);
    assign w_dy1 = DIFF_W'(r_mid_y) - DIFF_W'(r_old_y);
    assign w_dx2 = DIFF_W'(r_in_x) - DIFF_W'(r_mid_x);
    assign w_dy2 = DIFF_W'(r_in_y) - DIFF_W'(r_mid_y);
    assign w_ex1 = MUL_W'(w_dx1);
    assign w_ey1 = MUL_W'(w_dy1);
    assign w_ex2 = MUL_W'(w_dx2);
    assign w_ey2 = MUL_W'(w_dy2);

    // wide operands split into two unsigned digits
    assign w_lmin_ext = PAIR_W'(r_lmin);
    assign w_cmag_ext = PAIR_W'(r_cmag);
    assign w_prec_ext = PAIR_W'(r_prec_sq);
    assign w_wide_a   = (i_cmd.mul_phase == MP_LHS) ? w_cmag_ext : w_lmin_ext;
    assign w_wide_b   = (i_cmd.mul_phase == MP_LHS) ? w_cmag_ext : w_prec_ext;
    assign w_a_lo     = $signed({1'b0, w_wide_a[DIG_W-1:0]});
    assign w_a_hi     = $signed({1'b0, w_wide_a[PAIR_W-1:DIG_W]});
    assign w_b_lo     = $signed({1'b0, w_wide_b[DIG_W-1:0]});
    assign w_b_hi     = $signed({1'b0, w_wide_b[PAIR_W-1:DIG_W]});

    // operand select for the four lanes
    always_comb begin
        case (i_cmd.mul_phase)
            MP_DOT: begin
                w_op_a[0] = w_ex1; w_op_b[0] = w_ex2;
                w_op_a[1] = w_ey1; w_op_b[1] = w_ey2;
                w_op_a[2] = w_ex1; w_op_b[2] = w_ey2;
                w_op_a[3] = w_ey1; w_op_b[3] = w_ex2;
            end
            MP_RHS, MP_LHS: begin
                w_op_a[0] = w_a_lo; w_op_b[0] = w_b_lo;
                w_op_a[1] = w_a_lo; w_op_b[1] = w_b_hi;
                w_op_a[2] = w_a_hi; w_op_b[2] = w_b_lo;
                w_op_a[3] = w_a_hi; w_op_b[3] = w_b_hi;
            end
            default: begin
                w_op_a[0] = w_ex1; w_op_b[0] = w_ex1;
                w_op_a[1] = w_ey1; w_op_b[1] = w_ey1;
                w_op_a[2] = w_ex2; w_op_b[2] = w_ex2;
                w_op_a[3] = w_ey2; w_op_b[3] = w_ey2;
            end
        endcase
    end

    // multiplier lanes
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_prod[k] <= w_op_a[k] * w_op_b[k];
        end
    end

    // lane combining
    assign w_sum01     = r_prod[0] + r_prod[1];
    assign w_sum23     = r_prod[2] + r_prod[3];
    assign w_dif23     = r_prod[2] - r_prod[3];
    assign w_cross_neg = -r_cross;
    assign w_wide_sum  = WIDE_W'(r_prod[0][PAIR_W-1:0])
                       + (WIDE_W'(r_prod[1][PAIR_W-1:0]) << DIG_W)
                       + (WIDE_W'(r_prod[2][PAIR_W-1:0]) << DIG_W)
                       + (WIDE_W'(r_prod[3][PAIR_W-1:0]) << PAIR_W);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_len) begin
            r_l1 <= w_sum01[LEN_W-1:0];
            r_l2 <= w_sum23[LEN_W-1:0];
        end
        if (i_cmd.cap_dot) begin
            r_dot   <= w_sum01[DOT_W-1:0];
            r_cross <= w_dif23[DOT_W-1:0];
        end
        if (i_cmd.cap_rhs) begin
            r_rhs <= w_wide_sum;
        end
        if (i_cmd.cap_lhs) begin
            r_lhs <= w_wide_sum;
        end
        r_lmin <= (r_l1 < r_l2) ? r_l1 : r_l2;
        r_cmag <= r_cross[DOT_W-1] ? w_cross_neg[LEN_W-1:0] : r_cross[LEN_W-1:0];
    end

    // pressure tolerance against both neighbours
    assign w_old_p = PT_W'(r_old_p);
    assign w_mid_p = PT_W'(r_mid_p);
    assign w_in_p  = PT_W'(r_in_p);
    assign w_pd1   = (w_old_p > w_mid_p) ? w_old_p - w_mid_p : w_mid_p - w_old_p;
    assign w_pd2   = (w_in_p > w_mid_p) ? w_in_p - w_mid_p : w_mid_p - w_in_p;

    always_ff @(posedge i_clk) begin
        r_pres_ok <= (w_pd1 <= PT_W'(r_pres_tol)) && (w_pd2 <= PT_W'(r_pres_tol));
    end

    // drop decision and status
    assign o_status.drop_ok  = r_pres_ok && (r_l1 != '0) && (r_l2 != '0)
                             && !r_dot[DOT_W-1] && (r_dot != '0) && (r_lhs <= r_rhs);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.in_end   = r_in_end;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_x    <= i_cmd.emit_new ? r_in_x : r_mid_x;
            r_out_y    <= i_cmd.emit_new ? r_in_y : r_mid_y;
            r_out_p    <= i_cmd.emit_new ? r_in_p : r_mid_p;
            r_out_last <= i_cmd.emit_new ? r_in_end : 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_p     = r_out_p;
    assign o_out_last  = r_out_last;

endmodule

[design/pen_stroke_point_simplifier_core.sv]
// ----------------------------------------------------------------------------
// pen_stroke_point_simplifier_core
// Thins a stream of pen samples: a middle sample is dropped when its
// pressure matches both neighbours and its deviation stays within precision.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_axis channel, kept samples leave on m_axis.
//   tlast in marks the end of a stroke; tlast out marks its last kept sample.
//   precision (index 0) and pressure tolerance (index 1) are written through
//   the cfg port while no stroke sample is in flight.
// Timing:
//   one sample is taken at a time. A sample that forces the held one out
//   untested skips the geometry test. The test runs as six steps on four
//   shared 18x18 multiplier lanes: squared lengths, dot and cross, then the
//   two wide products in digits. A kept sample shows on m_axis in the
//   cycle after its emit step.
// Reset:
//   synchronous, active low; the stroke state clears and both registers go
//   back to precision 16 and tolerance 51.
// Stall:
//   one output register holds a result; when m_axis stalls with it full, the
//   next result waits and s_axis tready stays low until it moves.
// ----------------------------------------------------------------------------
module pen_stroke_point_simplifier_core
    import pssimp_pkg::*;
#(
    parameter int COORD_WIDTH    = 16,
    parameter int PRESSURE_WIDTH = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: sample_x, sample_y, sample_pressure, zero pad
    input  logic [((2*COORD_WIDTH+PRESSURE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // tlast: stroke_end
    input  logic                  i_s_axis_tlast,
    // kept sample stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata: kept_x, kept_y, kept_pressure, zero pad
    output logic [((2*COORD_WIDTH+PRESSURE_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // tlast: kept_last
    output logic                  o_m_axis_tlast,
    // register writes
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int PAY_W   = 2 * COORD_WIDTH + PRESSURE_WIDTH;
    localparam int TDATA_W = ((PAY_W + 7) / 8) * 8;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    logic signed [COORD_WIDTH-1:0]    w_out_x, w_out_y;
    logic        [PRESSURE_WIDTH-1:0] w_out_p;

    pssimp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    pssimp_dp #(
        .COORD_WIDTH    (COORD_WIDTH),
        .PRESSURE_WIDTH (PRESSURE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_x      (i_s_axis_tdata[COORD_WIDTH-1:0]),
        .i_in_y      (i_s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .i_in_p      (i_s_axis_tdata[PAY_W-1:2*COORD_WIDTH]),
        .i_in_end    (i_s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_x     (w_out_x),
        .o_out_y     (w_out_y),
        .o_out_p     (w_out_p),
        .o_out_last  (o_m_axis_tlast)
    );

    // pack kept sample, pad bits zero
    assign o_m_axis_tdata = TDATA_W'({w_out_p, w_out_y, w_out_x});

endmodule

[design/pssimp_checker.sv]
// ----------------------------------------------------------------------------
// pssimp_checker
// Port-level checks for the pen stroke simplifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "pen_stroke_point_simplifier_core_macros.svh"

module pssimp_checker #(
    parameter int COORD_WIDTH    = 16,
    parameter int PRESSURE_WIDTH = 10
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_axis_tvalid,
    input logic o_s_axis_tready,
    input logic o_m_axis_tvalid,
    input logic i_m_axis_tready,
    input logic [((2*COORD_WIDTH+PRESSURE_WIDTH+7)/8)*8-1:0] o_m_axis_tdata
);

    // a stalled kept sample stays put
    `PSSIMP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // one sample in flight: no accept right after an accept
    `PSSIMP_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

    // a new result is loaded only while the input side is closed
    `PSSIMP_ASSERT_SAME(a_emit_while_busy, i_clk, i_rst_n, $rose(o_m_axis_tvalid), !$past(o_s_axis_tready))

endmodule

bind pen_stroke_point_simplifier_core pssimp_checker #(
    .COORD_WIDTH    (COORD_WIDTH),
    .PRESSURE_WIDTH (PRESSURE_WIDTH)
) u_pssimp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
